@@ rtl/pvc_pkg.sv @@
// Shared types, constants and codes of the purge valve controller.
`default_nettype none
package pvc_pkg;

  localparam int unsigned PpmW    = 16;
  localparam int unsigned SecW    = 16;
  localparam int unsigned MsW     = 16;
  localparam int unsigned TimerW  = 26;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};
  localparam logic [TimerW-1:0] MsPerSec = TimerW'(1000);
  localparam logic [PpmW-1:0]   HystRst  = PpmW'(200);

  typedef enum logic [1:0] {
    OP_SERVICE = 2'd0,
    OP_START   = 2'd1,
    OP_STOP    = 2'd2,
    OP_READ_TO = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TARGET  = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_HYST    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [PpmW-1:0] target_ppm;
    logic [SecW-1:0] timeout_sec;
    logic [PpmW-1:0] hysteresis_ppm;
  } cfg_t;

  typedef struct packed {
    logic              run_enabled;
    logic              target_reached;
    logic              valve_state;
    logic              timeout_flag;
    logic [TimerW-1:0] run_timer_ms;
  } state_t;

  typedef struct packed {
    logic valve_is_open;
    logic still_purging;
    logic timeout_seen;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/pvc_if.sv @@
// Handshake channel interfaces of the purge valve controller.
`default_nettype none
interface pvc_in_if;
  logic                         valid;
  logic                         ready;
  pvc_pkg::op_e                 op;
  logic [pvc_pkg::PpmW-1:0]     oxygen_ppm;
  logic [pvc_pkg::MsW-1:0]      elapsed_ms;

  modport source (output valid, output op, output oxygen_ppm, output elapsed_ms,
                  input ready);
  modport sink (input valid, input op, input oxygen_ppm, input elapsed_ms,
                output ready);
endinterface

interface pvc_out_if;
  logic valid;
  logic ready;
  logic valve_is_open;
  logic still_purging;
  logic timeout_seen;

  modport source (output valid, output valve_is_open, output still_purging,
                  output timeout_seen, input ready);
  modport sink (input valid, input valve_is_open, input still_purging,
                input timeout_seen, output ready);
endinterface

interface pvc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pvc_pkg::CfgIdxW-1:0]   index;
  logic [pvc_pkg::CfgDatW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/purge_valve_controller.sv @@
// Top level of the purge valve controller: input stage, state and result register.
//
//  channel | direction | beat carries
//  in_ch   | in        | op, oxygen_ppm, elapsed_ms
//  out_ch  | out       | valve_is_open, still_purging, timeout_seen
//  cfg_ch  | in        | index, data (0 target, 1 timeout, 2 hysteresis)
//
// One item per cycle unless out_ch stalls; input register, then result register.
// The input register feeds the update logic, which writes the state and the
// result register in the same cycle, so consecutive items chain through the state.
// Reset clears state, cfg registers (hysteresis to 200) and both valid bits.
// A stalled result holds its register; the input stage keeps accepting while
// the result register is free or being drained in the same cycle.
`default_nettype none
module purge_valve_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  pvc_in_if.sink     in_ch,
  pvc_out_if.source  out_ch,
  pvc_cfg_if.sink    cfg_ch
);

  pvc_pkg::cfg_t    cfg_q;
  pvc_pkg::state_t  state_q;
  pvc_pkg::state_t  state_d;
  pvc_pkg::result_t res_q;
  pvc_pkg::result_t res_d;

  logic                       in_valid_q;
  pvc_pkg::op_e               op_q;
  logic [pvc_pkg::PpmW-1:0]   o2_q;
  logic [pvc_pkg::MsW-1:0]    el_q;
  logic                       out_valid_q;
  logic                       out_free;
  logic                       adv;
  logic                       in_fire;

  assign out_free     = ~out_valid_q | out_ch.ready;
  assign adv          = in_valid_q & out_free;
  assign in_ch.ready  = ~in_valid_q | out_free;
  assign in_fire      = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_ppm     <= '0;
      cfg_q.timeout_sec    <= '0;
      cfg_q.hysteresis_ppm <= pvc_pkg::HystRst;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        pvc_pkg::REG_TARGET:  cfg_q.target_ppm     <= cfg_ch.data;
        pvc_pkg::REG_TIMEOUT: cfg_q.timeout_sec    <= cfg_ch.data;
        pvc_pkg::REG_HYST:    cfg_q.hysteresis_ppm <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q <= in_ch.op;
      o2_q <= in_ch.oxygen_ppm;
      el_q <= in_ch.elapsed_ms;
    end
  end

  pvc_step u_step (
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .op_i         (op_q),
    .oxygen_ppm_i (o2_q),
    .elapsed_ms_i (el_q),
    .state_o      (state_d),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.valve_is_open = res_q.valve_is_open;
  assign out_ch.still_purging = res_q.still_purging;
  assign out_ch.timeout_seen  = res_q.timeout_seen;

  // A timeout always stops the purge, and only a start re-enables it after
  // clearing the flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.run_enabled && state_q.timeout_flag))
    else $error("purge enabled while timeout flag set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.target_reached |-> state_q.run_enabled)
    else $error("target reached without a running purge");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(state_q))
    else $error("state changed without an item being processed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result appeared without an item in the input stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ch.ready && in_valid_q) |-> !in_ch.ready)
    else $error("input stage overwritten while full and stalled");

endmodule
`default_nettype wire

@@ rtl/pvc_step.sv @@
// Next-state and result logic for one controller item.
`default_nettype none
module pvc_step (
  input  pvc_pkg::state_t                state_i,
  input  pvc_pkg::cfg_t                  cfg_i,
  input  pvc_pkg::op_e                   op_i,
  input  logic [pvc_pkg::PpmW-1:0]       oxygen_ppm_i,
  input  logic [pvc_pkg::MsW-1:0]        elapsed_ms_i,
  output pvc_pkg::state_t                state_o,
  output pvc_pkg::result_t               result_o
);

  logic [pvc_pkg::TimerW:0]   timer_sum;
  logic [pvc_pkg::TimerW-1:0] timer_sat;
  logic [pvc_pkg::TimerW-1:0] limit_ms;
  logic [pvc_pkg::PpmW-1:0]   upper_ppm;
  logic                       at_target;
  logic                       expired;
  logic                       seen;

  assign timer_sum = {1'b0, state_i.run_timer_ms} + (pvc_pkg::TimerW+1)'(elapsed_ms_i);
  assign timer_sat = (timer_sum > {1'b0, pvc_pkg::TimerMax}) ? pvc_pkg::TimerMax
                                                              : timer_sum[pvc_pkg::TimerW-1:0];

  // 65535 s in milliseconds still fits the 26-bit timer.
  assign limit_ms  = pvc_pkg::TimerW'(cfg_i.timeout_sec) * pvc_pkg::MsPerSec;
  assign upper_ppm = cfg_i.target_ppm + cfg_i.hysteresis_ppm;
  assign at_target = oxygen_ppm_i <= cfg_i.target_ppm;
  assign expired   = (cfg_i.timeout_sec != '0) && (timer_sat >= limit_ms);

  always_comb begin
    state_o              = state_i;
    state_o.run_timer_ms = timer_sat;
    seen                 = state_i.timeout_flag;
    case (op_i)
      pvc_pkg::OP_SERVICE: begin
        if (state_i.run_enabled && (cfg_i.target_ppm != '0)) begin
          if (!state_i.target_reached) begin
            if (at_target) begin
              state_o.target_reached = 1'b1;
              state_o.valve_state    = 1'b0;
            end else if (expired) begin
              state_o.timeout_flag = 1'b1;
              state_o.run_enabled  = 1'b0;
              state_o.valve_state  = 1'b0;
            end
          end else if (!state_i.valve_state && (oxygen_ppm_i > upper_ppm)) begin
            state_o.valve_state = 1'b1;
          end else if (state_i.valve_state && at_target) begin
            state_o.valve_state = 1'b0;
          end
        end
        seen = state_o.timeout_flag;
      end
      pvc_pkg::OP_START: begin
        state_o.run_enabled    = 1'b1;
        state_o.target_reached = 1'b0;
        state_o.timeout_flag   = 1'b0;
        state_o.run_timer_ms   = '0;
        state_o.valve_state    = 1'b1;
        seen                   = 1'b0;
      end
      pvc_pkg::OP_STOP: begin
        state_o.run_enabled    = 1'b0;
        state_o.target_reached = 1'b0;
        state_o.valve_state    = 1'b0;
      end
      pvc_pkg::OP_READ_TO: begin
        state_o.timeout_flag = 1'b0;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

  assign result_o.valve_is_open = state_o.valve_state;
  assign result_o.still_purging = state_o.run_enabled & ~state_o.target_reached;
  assign result_o.timeout_seen  = seen;

endmodule
`default_nettype wire
